>>> hw/rtl/stg_pkg.sv
`default_nettype none

package stg_pkg;

	// Tableau size. Every column is WORDS words of WORD_BITS bits.
	localparam int QUBITS = 256;
	localparam int WORD_BITS = 64;
	localparam int WORDS = (QUBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH = QUBITS * WORDS;

	// Index widths follow from the sizes above.
	localparam int COL_W = $clog2(QUBITS);
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ADDR_W = $clog2(DEPTH);

	// Compare and subtract steps that fold the 8-bit column and the 2-bit word fields.
	localparam int COL_STEPS = (256 + QUBITS - 1) / QUBITS - 1;
	localparam int WIDX_STEPS = (4 + WORDS - 1) / WORDS - 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [63:0] field_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [WIDX_W-1:0] widx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Operation codes.
	localparam logic [4:0] OP_I = 5'd0;
	localparam logic [4:0] OP_H = 5'd1;
	localparam logic [4:0] OP_S = 5'd2;
	localparam logic [4:0] OP_Z = 5'd3;
	localparam logic [4:0] OP_R = 5'd4;
	localparam logic [4:0] OP_X = 5'd5;
	localparam logic [4:0] OP_Y = 5'd6;
	localparam logic [4:0] OP_HX = 5'd7;
	localparam logic [4:0] OP_SX = 5'd8;
	localparam logic [4:0] OP_RX = 5'd9;
	localparam logic [4:0] OP_HZ = 5'd10;
	localparam logic [4:0] OP_HY = 5'd11;
	localparam logic [4:0] OP_SH = 5'd12;
	localparam logic [4:0] OP_RH = 5'd13;
	localparam logic [4:0] OP_HS = 5'd14;
	localparam logic [4:0] OP_HR = 5'd15;
	localparam logic [4:0] OP_HSX = 5'd16;
	localparam logic [4:0] OP_HRX = 5'd17;
	localparam logic [4:0] OP_SHY = 5'd18;
	localparam logic [4:0] OP_RHY = 5'd19;
	localparam logic [4:0] OP_HSH = 5'd20;
	localparam logic [4:0] OP_HRH = 5'd21;
	localparam logic [4:0] OP_RHS = 5'd22;
	localparam logic [4:0] OP_SHR = 5'd23;
	localparam logic [4:0] OP_CNOT = 5'd24;
	localparam logic [4:0] OP_CZ = 5'd25;
	localparam logic [4:0] OP_LOAD = 5'd26;
	localparam logic [4:0] OP_READ = 5'd27;

	// Input and result beats.
	typedef struct packed {
		logic [4:0] op;
		logic [7:0] ctrl;
		logic [7:0] targ;
		logic [1:0] word_index;
		logic [63:0] x_in;
		logic [63:0] z_in;
		logic [63:0] phase_in;
	} item_t;

	typedef struct packed {
		logic [63:0] x_out;
		logic [63:0] z_out;
		logic [63:0] phase_out;
		logic is_read;
		logic error;
	} result_t;

	// Operands and results of the word update unit.
	typedef struct packed {
		word_t ax;
		word_t az;
		word_t bx;
		word_t bz;
		word_t r;
	} word_in_t;

	typedef struct packed {
		word_t tx;
		word_t tz;
		word_t cz;
		word_t r;
	} word_out_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G1_RD,
		ST_G1_UPD,
		ST_T_RDC,
		ST_T_RDT,
		ST_T_UPD,
		ST_T_WRZ,
		ST_LOAD,
		ST_RD,
		ST_DONE
	} state_e;

	// Fold an 8-bit column number into the tableau.
	function automatic col_t col_reduce(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int k = 0; k < COL_STEPS; k++) begin
			if (int'(r) >= QUBITS) begin
				r = r - 8'(QUBITS);
			end
		end
		return col_t'(r);
	endfunction

	// Fold a 2-bit word number into the column.
	function automatic widx_t widx_reduce(input logic [1:0] v);
		logic [1:0] r;
		r = v;
		for (int k = 0; k < WIDX_STEPS; k++) begin
			if (int'(r) >= WORDS) begin
				r = r - 2'(WORDS);
			end
		end
		return widx_t'(r);
	endfunction

	// Memory address of one word of one column.
	function automatic addr_t word_addr(input col_t c, input widx_t w);
		return addr_t'(addr_t'(addr_t'(c) * addr_t'(WORDS)) + addr_t'(w));
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stg_ram.sv
`default_nettype none

module stg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/stg_word_unit.sv
`default_nettype none

module stg_word_unit (
	input wire logic [4:0] op,
	input wire stg_pkg::word_in_t din,
	output stg_pkg::word_out_t dout
);

	stg_pkg::word_t x;
	stg_pkg::word_t z;
	stg_pkg::word_t nx;
	stg_pkg::word_t nz;
	stg_pkg::word_t ncz;
	stg_pkg::word_t dr;

	assign x = din.bx;
	assign z = din.bz;

	// Bitwise update of one word of the target column, the control column and the phase.
	always_comb begin
		nx = x;
		nz = z;
		ncz = din.az;
		dr = '0;
		case (op)
			stg_pkg::OP_H: begin
				nx = z; nz = x; dr = x & z;
			end
			stg_pkg::OP_S: begin
				nz = x ^ z; dr = x & z;
			end
			stg_pkg::OP_Z: begin
				dr = x;
			end
			stg_pkg::OP_R: begin
				nz = x ^ z; dr = x & ~z;
			end
			stg_pkg::OP_X: begin
				dr = z;
			end
			stg_pkg::OP_Y: begin
				dr = x ^ z;
			end
			stg_pkg::OP_HX: begin
				nx = z; nz = x; dr = ~x & z;
			end
			stg_pkg::OP_SX: begin
				nz = x ^ z; dr = ~x & z;
			end
			stg_pkg::OP_RX: begin
				nz = x ^ z; dr = x | z;
			end
			stg_pkg::OP_HZ: begin
				nx = z; nz = x; dr = x & ~z;
			end
			stg_pkg::OP_HY: begin
				nx = z; nz = x; dr = x | z;
			end
			stg_pkg::OP_SH: begin
				nx = z; nz = x ^ z;
			end
			stg_pkg::OP_RH: begin
				nx = z; nz = x ^ z; dr = z;
			end
			stg_pkg::OP_HS: begin
				nx = x ^ z; nz = x; dr = x;
			end
			stg_pkg::OP_HR: begin
				nx = x ^ z; nz = x;
			end
			stg_pkg::OP_HSX: begin
				nx = x ^ z; nz = x; dr = x ^ z;
			end
			stg_pkg::OP_HRX: begin
				nx = x ^ z; nz = x; dr = z;
			end
			stg_pkg::OP_SHY: begin
				nx = z; nz = x ^ z; dr = x ^ z;
			end
			stg_pkg::OP_RHY: begin
				nx = z; nz = x ^ z; dr = x;
			end
			stg_pkg::OP_HSH: begin
				nx = x ^ z; dr = ~x & z;
			end
			stg_pkg::OP_HRH: begin
				nx = x ^ z; dr = x & z;
			end
			stg_pkg::OP_RHS: begin
				nx = x ^ z; dr = x | z;
			end
			stg_pkg::OP_SHR: begin
				nx = x ^ z; dr = x & ~z;
			end
			stg_pkg::OP_CNOT: begin
				dr = (din.ax & z) & ~(x ^ din.az);
				nx = x ^ din.ax;
				ncz = din.az ^ z;
			end
			stg_pkg::OP_CZ: begin
				dr = (din.ax & x) & (din.az ^ z);
				nz = z ^ din.ax;
				ncz = din.az ^ x;
			end
			default: begin
				nx = x;
			end
		endcase
	end

	assign dout.tx = nx;
	assign dout.tz = nz;
	assign dout.cz = ncz;
	assign dout.r = din.r ^ dr;

endmodule

`default_nettype wire

>>> hw/rtl/stabilizer_tableau_gate_engine.sv
// Single-qubit gate: the target words are read and rewritten in turn before the result beat.
// CNOT and CZ step through the words one at a time, bound by the single read port of the X and Z
// memories (control and target words are read one after the other, CZ writes Z twice).
// Load and read touch one addressed word, an ignored or unknown op none; items are taken only in idle.
// Reset clears the sequencer and the result valid; the tableau memories and the phase words
// keep undefined contents until loaded.
`default_nettype none

module stabilizer_tableau_gate_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire stg_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output stg_pkg::result_t result
);

	stg_pkg::state_e state_q;
	stg_pkg::state_e state_d;

	logic [4:0] op_q;
	stg_pkg::col_t c_q;
	stg_pkg::col_t t_q;
	stg_pkg::widx_t w_q;
	stg_pkg::word_t xin_q;
	stg_pkg::word_t zin_q;
	stg_pkg::word_t pin_q;

	stg_pkg::widx_t w_cnt_q;
	stg_pkg::word_t ax_q;
	stg_pkg::word_t az_q;
	stg_pkg::word_t tz_hold_q;
	stg_pkg::word_t phase_q [stg_pkg::WORDS];

	stg_pkg::col_t in_c;
	stg_pkg::col_t in_t;
	logic accept;
	logic w_last;
	logic out_free;
	logic is_two_q;

	// Memory and sequencer controls.
	logic re;
	stg_pkg::addr_t raddr;
	logic x_we;
	logic z_we;
	stg_pkg::addr_t x_waddr;
	stg_pkg::addr_t z_waddr;
	stg_pkg::word_t x_wdata;
	stg_pkg::word_t z_wdata;
	stg_pkg::word_t x_rdata;
	stg_pkg::word_t z_rdata;
	logic phase_we;
	stg_pkg::widx_t phase_widx;
	stg_pkg::word_t phase_wdata;
	logic w_inc;
	logic a_latch;
	logic tz_latch;
	logic res_load;

	stg_pkg::word_in_t unit_in;
	stg_pkg::word_out_t unit_out;
	stg_pkg::result_t result_d;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != stg_pkg::ST_IDLE);
	assign in_c = stg_pkg::col_reduce(item.ctrl);
	assign in_t = stg_pkg::col_reduce(item.targ);
	assign w_last = (w_cnt_q == stg_pkg::widx_t'(stg_pkg::WORDS - 1));
	assign out_free = !result_valid || !result_stall;
	assign is_two_q = (op_q == stg_pkg::OP_CNOT) || (op_q == stg_pkg::OP_CZ);

	// Tableau column memories.
	stg_ram #(
		.WIDTH(stg_pkg::WORD_BITS),
		.DEPTH(stg_pkg::DEPTH)
	) u_x_ram (
		.clk(clk),
		.we(x_we),
		.waddr(x_waddr),
		.wdata(x_wdata),
		.re(re),
		.raddr(raddr),
		.rdata(x_rdata)
	);

	stg_ram #(
		.WIDTH(stg_pkg::WORD_BITS),
		.DEPTH(stg_pkg::DEPTH)
	) u_z_ram (
		.clk(clk),
		.we(z_we),
		.waddr(z_waddr),
		.wdata(z_wdata),
		.re(re),
		.raddr(raddr),
		.rdata(z_rdata)
	);

	// Shared word update unit.
	assign unit_in.ax = ax_q;
	assign unit_in.az = az_q;
	assign unit_in.bx = x_rdata;
	assign unit_in.bz = z_rdata;
	assign unit_in.r = phase_q[w_cnt_q];

	stg_word_unit u_unit (
		.op(op_q),
		.din(unit_in),
		.dout(unit_out)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			stg_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.op <= stg_pkg::OP_SHR) begin
						state_d = stg_pkg::ST_G1_RD;
					end else if (item.op == stg_pkg::OP_CNOT || item.op == stg_pkg::OP_CZ) begin
						state_d = (in_c == in_t) ? stg_pkg::ST_DONE : stg_pkg::ST_T_RDC;
					end else if (item.op == stg_pkg::OP_LOAD) begin
						state_d = stg_pkg::ST_LOAD;
					end else if (item.op == stg_pkg::OP_READ) begin
						state_d = stg_pkg::ST_RD;
					end else begin
						state_d = stg_pkg::ST_DONE;
					end
				end
			end
			stg_pkg::ST_G1_RD: state_d = stg_pkg::ST_G1_UPD;
			stg_pkg::ST_G1_UPD: begin
				if (w_last) begin
					state_d = stg_pkg::ST_DONE;
				end
			end
			stg_pkg::ST_T_RDC: state_d = stg_pkg::ST_T_RDT;
			stg_pkg::ST_T_RDT: state_d = stg_pkg::ST_T_UPD;
			stg_pkg::ST_T_UPD: begin
				if (op_q == stg_pkg::OP_CZ) begin
					state_d = stg_pkg::ST_T_WRZ;
				end else begin
					state_d = w_last ? stg_pkg::ST_DONE : stg_pkg::ST_T_RDC;
				end
			end
			stg_pkg::ST_T_WRZ: state_d = w_last ? stg_pkg::ST_DONE : stg_pkg::ST_T_RDC;
			stg_pkg::ST_LOAD: state_d = stg_pkg::ST_DONE;
			stg_pkg::ST_RD: state_d = stg_pkg::ST_DONE;
			stg_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = stg_pkg::ST_IDLE;
				end
			end
			default: state_d = stg_pkg::ST_IDLE;
		endcase
	end

	// Memory, phase and counter controls for each state.
	always_comb begin
		re = 1'b0;
		raddr = '0;
		x_we = 1'b0;
		z_we = 1'b0;
		x_waddr = '0;
		z_waddr = '0;
		x_wdata = '0;
		z_wdata = '0;
		phase_we = 1'b0;
		phase_widx = w_cnt_q;
		phase_wdata = unit_out.r;
		w_inc = 1'b0;
		a_latch = 1'b0;
		tz_latch = 1'b0;
		res_load = 1'b0;
		case (state_q)
			stg_pkg::ST_G1_RD: begin
				re = 1'b1;
				raddr = stg_pkg::word_addr(t_q, w_cnt_q);
			end
			stg_pkg::ST_G1_UPD: begin
				x_we = 1'b1;
				z_we = 1'b1;
				x_waddr = stg_pkg::word_addr(t_q, w_cnt_q);
				z_waddr = stg_pkg::word_addr(t_q, w_cnt_q);
				x_wdata = unit_out.tx;
				z_wdata = unit_out.tz;
				phase_we = 1'b1;
				w_inc = !w_last;
				re = !w_last;
				raddr = stg_pkg::word_addr(t_q, stg_pkg::widx_t'(w_cnt_q + 1'b1));
			end
			stg_pkg::ST_T_RDC: begin
				re = 1'b1;
				raddr = stg_pkg::word_addr(c_q, w_cnt_q);
			end
			stg_pkg::ST_T_RDT: begin
				re = 1'b1;
				raddr = stg_pkg::word_addr(t_q, w_cnt_q);
				a_latch = 1'b1;
			end
			stg_pkg::ST_T_UPD: begin
				phase_we = 1'b1;
				z_we = 1'b1;
				z_waddr = stg_pkg::word_addr(c_q, w_cnt_q);
				z_wdata = unit_out.cz;
				if (op_q == stg_pkg::OP_CNOT) begin
					x_we = 1'b1;
					x_waddr = stg_pkg::word_addr(t_q, w_cnt_q);
					x_wdata = unit_out.tx;
					w_inc = !w_last;
				end else begin
					tz_latch = 1'b1;
				end
			end
			stg_pkg::ST_T_WRZ: begin
				z_we = 1'b1;
				z_waddr = stg_pkg::word_addr(t_q, w_cnt_q);
				z_wdata = tz_hold_q;
				w_inc = !w_last;
			end
			stg_pkg::ST_LOAD: begin
				x_we = 1'b1;
				z_we = 1'b1;
				x_waddr = stg_pkg::word_addr(t_q, w_q);
				z_waddr = stg_pkg::word_addr(t_q, w_q);
				x_wdata = xin_q;
				z_wdata = zin_q;
				phase_we = 1'b1;
				phase_widx = w_q;
				phase_wdata = pin_q;
			end
			stg_pkg::ST_RD: begin
				re = 1'b1;
				raddr = stg_pkg::word_addr(t_q, w_q);
			end
			stg_pkg::ST_DONE: begin
				res_load = out_free;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// Result of the finished item; read data stays in the memory output registers.
	always_comb begin
		result_d = '0;
		if (op_q == stg_pkg::OP_READ) begin
			result_d.x_out = stg_pkg::field_t'(x_rdata);
			result_d.z_out = stg_pkg::field_t'(z_rdata);
			result_d.phase_out = stg_pkg::field_t'(phase_q[w_q]);
			result_d.is_read = 1'b1;
		end
		result_d.error = is_two_q && (c_q == t_q);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stg_pkg::ST_IDLE;
			w_cnt_q <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				w_cnt_q <= '0;
			end else if (w_inc) begin
				w_cnt_q <= stg_pkg::widx_t'(w_cnt_q + 1'b1);
			end
			if (res_load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Item, operand and phase registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.op;
			c_q <= in_c;
			t_q <= in_t;
			w_q <= stg_pkg::widx_reduce(item.word_index);
			xin_q <= item.x_in[stg_pkg::WORD_BITS-1:0];
			zin_q <= item.z_in[stg_pkg::WORD_BITS-1:0];
			pin_q <= item.phase_in[stg_pkg::WORD_BITS-1:0];
		end
		if (a_latch) begin
			ax_q <= x_rdata;
			az_q <= z_rdata;
		end
		if (tz_latch) begin
			tz_hold_q <= unit_out.tz;
		end
		if (phase_we) begin
			phase_q[phase_widx] <= phase_wdata;
		end
		if (res_load) begin
			result <= result_d;
		end
	end

`ifndef ASSERT_OFF
	// A memory never reads the word that it writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(re && x_we) |-> (raddr != x_waddr))
		else $error("x memory read and write collide");

	assert property (@(posedge clk) disable iff (!arst_n)
		(re && z_we) |-> (raddr != z_waddr))
		else $error("z memory read and write collide");

	// A two-qubit update runs only on distinct columns.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stg_pkg::ST_T_RDC) |-> (c_q != t_q))
		else $error("two-qubit gate started with equal columns");

	// A gate finishes only after its last word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stg_pkg::ST_G1_UPD && state_d == stg_pkg::ST_DONE) |-> w_last)
		else $error("single-qubit gate ended early");

	// A result beat appears only out of the finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == stg_pkg::ST_DONE))
		else $error("result beat without a finished item");
`endif

endmodule

`default_nettype wire

>>> dv/stabilizer_tableau_gate_engine_tb.sv
module stabilizer_tableau_gate_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stg_pkg::*;

	// Op codes that the block leaves unused.
	localparam logic [4:0] OP_SPARE_FIRST = 5'd28;
	localparam logic [4:0] OP_SPARE_LAST = 5'd31;

	localparam int RANDOM_ITEMS = 1030;
	localparam int POOL_COLUMNS = 10;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER = 150;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;

	// Shadow tableau plus the queue of results still owed by the block.
	class tableau_scoreboard;
		word_t x_col[DEPTH];
		word_t z_col[DEPTH];
		word_t phase_col[WORDS];
		result_t awaited[$];
		int mismatches = 0;
		int checked = 0;
		int single_gates = 0;
		int pair_gates = 0;
		int clashes = 0;
		int loads = 0;
		int reads = 0;
		int spares = 0;

		// One word of a single-qubit Clifford update on X, Z and phase.
		function void clifford_word(input logic [4:0] g, inout word_t x, inout word_t z,
				inout word_t r);
			word_t nx;
			word_t nz;
			word_t dr;
			nx = x;
			nz = z;
			dr = '0;
			case (g)
				OP_H: begin nx = z; nz = x; dr = x & z; end
				OP_S: begin nz = x ^ z; dr = x & z; end
				OP_Z: begin dr = x; end
				OP_R: begin nz = x ^ z; dr = x & ~z; end
				OP_X: begin dr = z; end
				OP_Y: begin dr = x ^ z; end
				OP_HX: begin nx = z; nz = x; dr = ~x & z; end
				OP_SX: begin nz = x ^ z; dr = ~x & z; end
				OP_RX: begin nz = x ^ z; dr = x | z; end
				OP_HZ: begin nx = z; nz = x; dr = x & ~z; end
				OP_HY: begin nx = z; nz = x; dr = x | z; end
				OP_SH: begin nx = z; nz = x ^ z; end
				OP_RH: begin nx = z; nz = x ^ z; dr = z; end
				OP_HS: begin nx = x ^ z; nz = x; dr = x; end
				OP_HR: begin nx = x ^ z; nz = x; end
				OP_HSX: begin nx = x ^ z; nz = x; dr = x ^ z; end
				OP_HRX: begin nx = x ^ z; nz = x; dr = z; end
				OP_SHY: begin nx = z; nz = x ^ z; dr = x ^ z; end
				OP_RHY: begin nx = z; nz = x ^ z; dr = x; end
				OP_HSH: begin nx = x ^ z; dr = ~x & z; end
				OP_HRH: begin nx = x ^ z; dr = x & z; end
				OP_RHS: begin nx = x ^ z; dr = x | z; end
				OP_SHR: begin nx = x ^ z; dr = x & ~z; end
				default: begin end
			endcase
			x = nx;
			z = nz;
			r = r ^ dr;
		endfunction

		// Apply one accepted input beat to the shadow tableau and queue its result.
		function void note_item(input item_t it);
			int c;
			int t;
			int w;
			int ca;
			int ta;
			word_t xa;
			word_t za;
			word_t ra;
			word_t ax;
			word_t az;
			word_t bx;
			word_t bz;
			result_t want;
			want = '0;
			c = int'(it.ctrl) % QUBITS;
			t = int'(it.targ) % QUBITS;
			w = int'(it.word_index) % WORDS;
			if (it.op <= OP_SHR) begin
				single_gates++;
				for (int i = 0; i < WORDS; i++) begin
					xa = x_col[t * WORDS + i];
					za = z_col[t * WORDS + i];
					ra = phase_col[i];
					clifford_word(it.op, xa, za, ra);
					x_col[t * WORDS + i] = xa;
					z_col[t * WORDS + i] = za;
					phase_col[i] = ra;
				end
			end else if (it.op == OP_CNOT || it.op == OP_CZ) begin
				if (c == t) begin
					// Same control and target: state untouched, error flagged.
					clashes++;
					want.error = 1'b1;
				end else begin
					pair_gates++;
					for (int i = 0; i < WORDS; i++) begin
						ca = c * WORDS + i;
						ta = t * WORDS + i;
						ax = x_col[ca];
						az = z_col[ca];
						bx = x_col[ta];
						bz = z_col[ta];
						if (it.op == OP_CNOT) begin
							phase_col[i] ^= (ax & bz) & ~(bx ^ az);
							x_col[ta] = bx ^ ax;
							z_col[ca] = az ^ bz;
						end else begin
							phase_col[i] ^= (ax & bx) & (az ^ bz);
							z_col[ta] = bz ^ ax;
							z_col[ca] = az ^ bx;
						end
					end
				end
			end else if (it.op == OP_LOAD) begin
				loads++;
				x_col[t * WORDS + w] = word_t'(it.x_in);
				z_col[t * WORDS + w] = word_t'(it.z_in);
				phase_col[w] = word_t'(it.phase_in);
			end else if (it.op == OP_READ) begin
				reads++;
				want.x_out = 64'(x_col[t * WORDS + w]);
				want.z_out = 64'(z_col[t * WORDS + w]);
				want.phase_out = 64'(phase_col[w]);
				want.is_read = 1'b1;
			end else begin
				spares++;
			end
			awaited.push_back(want);
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 40) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endtask

		// Compare one accepted result beat with the oldest expectation.
		task check_result(input result_t got);
			result_t want;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("result beat %0d arrived with nothing outstanding", checked));
			end else begin
				want = awaited.pop_front();
				if (got.x_out !== want.x_out) begin
					report($sformatf("beat %0d x_out %h, expected %h", checked, got.x_out,
						want.x_out));
				end
				if (got.z_out !== want.z_out) begin
					report($sformatf("beat %0d z_out %h, expected %h", checked, got.z_out,
						want.z_out));
				end
				if (got.phase_out !== want.phase_out) begin
					report($sformatf("beat %0d phase_out %h, expected %h", checked,
						got.phase_out, want.phase_out));
				end
				if (got.is_read !== want.is_read) begin
					report($sformatf("beat %0d is_read %b, expected %b", checked, got.is_read,
						want.is_read));
				end
				if (got.error !== want.error) begin
					report($sformatf("beat %0d error %b, expected %b", checked, got.error,
						want.error));
				end
			end
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	tableau_scoreboard sb = new;

	// Which tableau words hold loaded data, so gates and reads never touch garbage.
	bit word_loaded[DEPTH];
	int loaded_addrs[$];
	int ready_cols[$];
	int sent_count = 0;

	stabilizer_tableau_gate_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic item_t make_item(input logic [4:0] op, input logic [7:0] ctrl,
			input logic [7:0] targ, input logic [1:0] widx, input field_t x,
			input field_t z, input field_t p);
		item_t it;
		it.op = op;
		it.ctrl = ctrl;
		it.targ = targ;
		it.word_index = widx;
		it.x_in = x;
		it.z_in = z;
		it.phase_in = p;
		return it;
	endfunction

	// Track loaded words; a column becomes usable for gates once all its words are in.
	function automatic void track_load(input item_t it);
		int col;
		int addr;
		bit full;
		col = int'(it.targ) % QUBITS;
		addr = col * WORDS + int'(it.word_index) % WORDS;
		if (!word_loaded[addr]) begin
			word_loaded[addr] = 1'b1;
			loaded_addrs.push_back(addr);
			full = 1'b1;
			for (int i = 0; i < WORDS; i++) begin
				if (!word_loaded[col * WORDS + i]) begin
					full = 1'b0;
				end
			end
			if (full) begin
				ready_cols.push_back(col);
			end
		end
	endfunction

	function automatic field_t random_word();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return '1;
		end else if (pick == 1) begin
			return '0;
		end
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] ready_col();
		return 8'(ready_cols[$urandom_range(0, ready_cols.size() - 1)]);
	endfunction

	// Mostly gates on loaded columns, with loads, reads, clashes and spare codes mixed in.
	function automatic item_t random_item();
		item_t it;
		int pick;
		int addr;
		it = make_item(5'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
			random_word(), random_word(), random_word());
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.op = OP_LOAD;
			if ($urandom_range(0, 3) != 0) begin
				it.targ = ready_col();
			end
		end else if (pick < 27) begin
			addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
			it.op = OP_READ;
			it.targ = 8'(addr / WORDS);
			it.word_index = 2'(addr % WORDS);
		end else if (pick < 72) begin
			it.op = 5'($urandom_range(OP_I, OP_SHR));
			it.targ = ready_col();
		end else if (pick < 95) begin
			it.op = ($urandom_range(0, 1) == 0) ? OP_CNOT : OP_CZ;
			if ($urandom_range(0, 9) == 0) begin
				it.targ = it.ctrl;
			end else begin
				it.ctrl = ready_col();
				it.targ = ready_col();
			end
		end else begin
			it.op = 5'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		return it;
	endfunction

	// Sender gaps: mostly none, some short, a few long, with gap-free stretches.
	function automatic int sender_gap();
		int pick;
		if ((sent_count / 64) % 3 == 2) begin
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 0;
		end else if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Offer one input beat and wait for it to be taken.
	task automatic send_item(input item_t it);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (it.op == OP_LOAD) begin
			track_load(it);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		sb.note_item(it);
		sent_count++;
	endtask

	// Stimulus: reset, directed beats, then column setup and random traffic.
	initial begin : stimulus
		field_t ones;
		field_t alt;
		ones = '1;
		alt = 64'hAAAA_AAAA_AAAA_AAAA;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill columns 0 and 255 with extreme patterns.
		send_item(make_item(OP_LOAD, 8'h00, 8'h00, 2'd0, ones, '0, alt));
		send_item(make_item(OP_LOAD, 8'h00, 8'h00, 2'd1, '0, ones, ~alt));
		send_item(make_item(OP_LOAD, 8'h00, 8'h00, 2'd2, alt, ~alt, ones));
		send_item(make_item(OP_LOAD, 8'h00, 8'h00, 2'd3, 64'h8000_0000_0000_0001, ones, '0));
		send_item(make_item(OP_LOAD, 8'hFF, 8'hFF, 2'd0, ~alt, alt, '0));
		send_item(make_item(OP_LOAD, 8'hFF, 8'hFF, 2'd1, ones, ones, ones));
		send_item(make_item(OP_LOAD, 8'hFF, 8'hFF, 2'd2, '0, '0, 64'h8000_0000_0000_0001));
		send_item(make_item(OP_LOAD, 8'hFF, 8'hFF, 2'd3, random_word(), random_word(),
			random_word()));
		send_item(make_item(OP_READ, 8'hFF, 8'h00, 2'd0, ones, ones, ones));
		send_item(make_item(OP_READ, 8'h00, 8'hFF, 2'd3, '0, '0, '0));

		// Gates, including the HY phase rule and both two-qubit ops.
		send_item(make_item(OP_H, 8'hFF, 8'h00, 2'd3, '0, '0, '0));
		send_item(make_item(OP_HY, 8'h00, 8'hFF, 2'd0, '0, '0, '0));
		send_item(make_item(OP_Y, 8'h00, 8'h00, 2'd0, '0, '0, '0));
		send_item(make_item(OP_CNOT, 8'h00, 8'hFF, 2'd0, '0, '0, '0));
		send_item(make_item(OP_CZ, 8'hFF, 8'h00, 2'd0, '0, '0, '0));

		// Same control and target must be refused with the error flag.
		send_item(make_item(OP_CNOT, 8'h07, 8'h07, 2'd0, '0, '0, '0));
		send_item(make_item(OP_CZ, 8'hFF, 8'hFF, 2'd3, ones, ones, ones));

		// Unused codes give an empty result.
		send_item(make_item(OP_SPARE_LAST, 8'hFF, 8'hFF, 2'd3, ones, ones, ones));
		send_item(make_item(OP_SPARE_FIRST, 8'h00, 8'h00, 2'd0, '0, '0, '0));
		send_item(make_item(OP_I, 8'h12, 8'hFF, 2'd1, '0, '0, '0));

		// Read back what the gates left behind.
		send_item(make_item(OP_READ, 8'h00, 8'h00, 2'd1, '0, '0, '0));
		send_item(make_item(OP_READ, 8'h00, 8'h00, 2'd2, '0, '0, '0));
		send_item(make_item(OP_READ, 8'h00, 8'h00, 2'd3, '0, '0, '0));
		send_item(make_item(OP_READ, 8'h00, 8'hFF, 2'd0, '0, '0, '0));
		send_item(make_item(OP_READ, 8'h00, 8'hFF, 2'd1, '0, '0, '0));
		send_item(make_item(OP_READ, 8'h00, 8'hFF, 2'd2, '0, '0, '0));

		// Bring a handful of random columns into use.
		for (int n = 0; n < POOL_COLUMNS; n++) begin
			automatic logic [7:0] col = 8'($urandom_range(1, 254));
			for (int w = 0; w < WORDS; w++) begin
				send_item(make_item(OP_LOAD, 8'($urandom), col, 2'(w), random_word(),
					random_word(), random_word()));
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_item(random_item());
		end
		item_valid <= 1'b0;

		// Drain outstanding results, then give the block time to misbehave.
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d beats: %0d single-qubit gates, %0d CNOT/CZ, %0d refused pairs,",
			sent_count, sb.single_gates, sb.pair_gates, sb.clashes);
		$display("%0d loads, %0d reads, %0d unused codes; %0d results compared, %0d mismatches.",
			sb.loads, sb.reads, sb.spares, sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Result side: random stalls, gap-free windows and one long hold-off to back the block up.
	initial begin : result_sink
		int hold;
		int pick;
		int cyc;
		bit pressure_done;
		hold = 0;
		cyc = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (result_valid && !result_stall) begin
				sb.check_result(result);
			end
			if (hold > 0) begin
				hold--;
			end else if (!pressure_done && sb.checked >= HOLD_OFF_AFTER) begin
				pressure_done = 1'b1;
				hold = HOLD_OFF_CYCLES;
			end else if ((cyc / 250) % 4 == 3) begin
				hold = 0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					hold = 0;
				end else if (pick < 95) begin
					hold = $urandom_range(1, 4);
				end else begin
					hold = $urandom_range(10, 60);
				end
			end
			result_stall <= (hold > 0);
		end
	end

	// Give up when no beat moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule
